[rtl/htfc_pkg.sv]
// shared widths, register indexes, reset values and bundle types for the frame checker
`default_nettype none
package htfc_pkg;

	localparam int BYTE_W      = 8;
	localparam int TEMP_W      = 15;
	localparam int HUMID_W     = 14;
	localparam int RAW_W       = 16;
	localparam int CFG_INDEX_W = 8;
	localparam int IN_TDATA_W  = 6 * BYTE_W;
	localparam int OUT_DATA_W  = TEMP_W + HUMID_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_SEED = CFG_INDEX_W'(1);

	localparam logic [BYTE_W-1:0] POLY_RESET = 8'h31;
	localparam logic [BYTE_W-1:0] SEED_RESET = 8'hFF;

	typedef struct packed {
		logic [BYTE_W-1:0] poly;
		logic [BYTE_W-1:0] seed;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] humid_check;
		logic [BYTE_W-1:0] humid_low;
		logic [BYTE_W-1:0] humid_high;
		logic [BYTE_W-1:0] temp_check;
		logic [BYTE_W-1:0] temp_low;
		logic [BYTE_W-1:0] temp_high;
	} frame_t;

	typedef struct packed {
		logic                      status;
		logic signed [TEMP_W-1:0]  temperature_centi_c;
		logic        [HUMID_W-1:0] humidity_centi_pct;
	} result_t;

endpackage
`default_nettype wire

[rtl/htfc_crc_check.sv]
// crc-8 over one big-endian word, msb first, compared against the received check byte
`default_nettype none
module htfc_crc_check (
	input  wire htfc_pkg::cfg_t                   cfg,
	input  wire logic [htfc_pkg::BYTE_W-1:0]      word_high,
	input  wire logic [htfc_pkg::BYTE_W-1:0]      word_low,
	input  wire logic [htfc_pkg::BYTE_W-1:0]      check,
	output logic                                  mismatch
);

	function automatic logic [htfc_pkg::BYTE_W-1:0] crc8_byte(
		input logic [htfc_pkg::BYTE_W-1:0] crc_in,
		input logic [htfc_pkg::BYTE_W-1:0] data,
		input logic [htfc_pkg::BYTE_W-1:0] poly
	);
		logic [htfc_pkg::BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int k = 0; k < htfc_pkg::BYTE_W; k++) begin
			if (c[htfc_pkg::BYTE_W-1]) begin
				c = (c << 1) ^ poly;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	logic [htfc_pkg::BYTE_W-1:0] crc_mid;
	logic [htfc_pkg::BYTE_W-1:0] crc_end;

	always_comb begin
		crc_mid  = crc8_byte(cfg.seed, word_high, cfg.poly);
		crc_end  = crc8_byte(crc_mid, word_low, cfg.poly);
		mismatch = (crc_end != check);
	end

endmodule
`default_nettype wire

[rtl/htfc_convert.sv]
// rounded scaling of the raw words to centi-degrees and centi-percent, zeroed on crc error
`default_nettype none
module htfc_convert (
	input  wire logic [htfc_pkg::RAW_W-1:0] temp_raw,
	input  wire logic [htfc_pkg::RAW_W-1:0] humid_raw,
	input  wire logic                       crc_error,
	output htfc_pkg::result_t               result
);

	localparam int PROD_W = 31;
	localparam int Q_W    = PROD_W - htfc_pkg::RAW_W;
	localparam int R_W    = htfc_pkg::RAW_W + 1;

	localparam logic [PROD_W-1:0] TEMP_SCALE  = PROD_W'(17500);
	localparam logic [PROD_W-1:0] HUMID_SCALE = PROD_W'(10000);
	localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(32767);
	localparam logic [R_W-1:0]    FULL_SCALE  = R_W'(65535);
	localparam logic signed [htfc_pkg::TEMP_W:0] TEMP_OFFSET = (htfc_pkg::TEMP_W + 1)'(4500);

	// x / 65535: estimate with x >> 16, remainder stays below twice the divisor
	function automatic logic [Q_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
		logic [Q_W-1:0] q_est;
		logic [R_W-1:0] rem;
		q_est = x[PROD_W-1:htfc_pkg::RAW_W];
		rem   = {1'b0, x[htfc_pkg::RAW_W-1:0]} + R_W'(q_est);
		return (rem >= FULL_SCALE) ? q_est + Q_W'(1) : q_est;
	endfunction

	logic [PROD_W-1:0]                  temp_prod;
	logic [PROD_W-1:0]                  humid_prod;
	logic [Q_W-1:0]                     temp_q;
	logic [Q_W-1:0]                     humid_q;
	logic signed [htfc_pkg::TEMP_W:0]   temp_full;

	always_comb begin
		temp_prod  = TEMP_SCALE * PROD_W'(temp_raw) + ROUND_HALF;
		humid_prod = HUMID_SCALE * PROD_W'(humid_raw) + ROUND_HALF;
		temp_q     = div_full_scale(temp_prod);
		humid_q    = div_full_scale(humid_prod);
		temp_full  = $signed({1'b0, temp_q}) - TEMP_OFFSET;

		result.status = crc_error;
		if (crc_error) begin
			result.temperature_centi_c = '0;
			result.humidity_centi_pct  = '0;
		end else begin
			result.temperature_centi_c = temp_full[htfc_pkg::TEMP_W-1:0];
			result.humidity_centi_pct  = humid_q[htfc_pkg::HUMID_W-1:0];
		end
	end

endmodule
`default_nettype wire

[rtl/humidity_temp_frame_check_convert_unit.sv]
// top level: frame input register, crc checks, conversion and result register
// Each six-byte measurement frame is checked with two crc-8 computations (polynomial and
// seed from the configuration registers, index 0 and 1) and converted to centi-degrees C
// and centi-percent humidity; a crc mismatch in either word gives status 1 and zero
// readings. One frame is accepted every cycle while the output is not stalled, and
// the frame register feeds one combinational pass (crc over four bytes plus a constant
// multiply, add and compare per word) into the result register. Configuration writes are
// always taken and should only be issued while no frame is in flight.
`default_nettype none
module humidity_temp_frame_check_convert_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [htfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [htfc_pkg::BYTE_W-1:0]         cfg_data,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// temp_high, temp_low, temp_check, humid_high, humid_low, humid_check
	input  wire logic [htfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// temperature_centi_c, humidity_centi_pct, zero fill
	output logic [htfc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// status
	output logic [htfc_pkg::OUT_TUSER_W-1:0]         m_axis_tuser
);

	htfc_pkg::cfg_t    cfg_q;
	htfc_pkg::frame_t  frame_s1;
	logic              valid_s1;
	htfc_pkg::result_t result_s2;
	logic              valid_s2;
	htfc_pkg::result_t result_comb;
	logic              temp_mismatch;
	logic              humid_mismatch;
	logic              advance_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly <= htfc_pkg::POLY_RESET;
			cfg_q.seed <= htfc_pkg::SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == htfc_pkg::REG_CRC_POLY) begin
				cfg_q.poly <= cfg_data;
			end else if (cfg_index == htfc_pkg::REG_CRC_SEED) begin
				cfg_q.seed <= cfg_data;
			end
		end
	end

	// output stage frees when empty or its beat is taken
	assign advance_s2    = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			frame_s1 <= htfc_pkg::frame_t'(s_axis_tdata);
		end
	end

	htfc_crc_check u_temp_crc (
		.cfg       (cfg_q),
		.word_high (frame_s1.temp_high),
		.word_low  (frame_s1.temp_low),
		.check     (frame_s1.temp_check),
		.mismatch  (temp_mismatch)
	);

	htfc_crc_check u_humid_crc (
		.cfg       (cfg_q),
		.word_high (frame_s1.humid_high),
		.word_low  (frame_s1.humid_low),
		.check     (frame_s1.humid_check),
		.mismatch  (humid_mismatch)
	);

	htfc_convert u_convert (
		.temp_raw  ({frame_s1.temp_high, frame_s1.temp_low}),
		.humid_raw ({frame_s1.humid_high, frame_s1.humid_low}),
		.crc_error (temp_mismatch || humid_mismatch),
		.result    (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			result_s2 <= result_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		(htfc_pkg::OUT_TDATA_W - htfc_pkg::OUT_DATA_W)'(0),
		result_s2.humidity_centi_pct,
		result_s2.temperature_centi_c
	};
	assign m_axis_tuser  = result_s2.status;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// testbench for the crc-checked humidity and temperature frame converter
module tb;
	import htfc_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	class reading_checker;
		logic [BYTE_W-1:0] poly;
		logic [BYTE_W-1:0] seed;
		result_t expected_readings[$];
		int mismatches;
		int readings_checked;
		int crc_fail_readings;

		function new();
			poly = POLY_RESET;
			seed = SEED_RESET;
			mismatches = 0;
			readings_checked = 0;
			crc_fail_readings = 0;
		endfunction

		function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
			if (idx == REG_CRC_POLY) begin
				poly = val;
			end else if (idx == REG_CRC_SEED) begin
				seed = val;
			end
		endfunction

		function logic [BYTE_W-1:0] crc_word(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo);
			logic [BYTE_W-1:0] r;
			r = seed;
			for (int j = 0; j < 2; j++) begin
				r = r ^ ((j == 0) ? hi : lo);
				for (int k = 0; k < 8; k++) begin
					r = {r[6:0], 1'b0} ^ (r[7] ? poly : 8'h00);
				end
			end
			return r;
		endfunction

		function result_t predict_reading(frame_t f);
			result_t r;
			int unsigned traw;
			int unsigned hraw;
			int unsigned tscaled;
			int unsigned hscaled;
			int temp;
			r = '0;
			if (crc_word(f.temp_high, f.temp_low) != f.temp_check ||
			    crc_word(f.humid_high, f.humid_low) != f.humid_check) begin
				r.status = 1'b1;
				return r;
			end
			traw = {f.temp_high, f.temp_low};
			hraw = {f.humid_high, f.humid_low};
			tscaled = (32'd17500 * traw + 32'd32767) / 32'd65535;
			hscaled = (32'd10000 * hraw + 32'd32767) / 32'd65535;
			temp = int'(tscaled) - 4500;
			r.temperature_centi_c = temp[TEMP_W-1:0];
			r.humidity_centi_pct = hscaled[HUMID_W-1:0];
			return r;
		endfunction

		function void note_frame(frame_t f);
			expected_readings.push_back(predict_reading(f));
		endfunction

		function void check_reading(logic [OUT_TDATA_W-1:0] data, logic status);
			result_t want;
			logic [TEMP_W-1:0] got_temp;
			logic [HUMID_W-1:0] got_humid;
			got_temp = data[TEMP_W-1:0];
			got_humid = data[TEMP_W +: HUMID_W];
			if (expected_readings.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected reading: status %0b temp %0d humid %0d",
						status, $signed(got_temp), got_humid);
				mismatches++;
				return;
			end
			want = expected_readings.pop_front();
			readings_checked++;
			if (want.status)
				crc_fail_readings++;
			if (status !== want.status || got_temp !== want.temperature_centi_c ||
			    got_humid !== want.humidity_centi_pct) begin
				if (mismatches < 10)
					$display("reading mismatch: status %0b/%0b temp %0d/%0d humid %0d/%0d (exp/got)",
						want.status, status, want.temperature_centi_c, $signed(got_temp),
						want.humidity_centi_pct, got_humid);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	reading_checker sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int frames_accepted;
	int cfg_writes;

	humidity_temp_frame_check_convert_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5000000;
		$display("timeout waiting for readings");
		$display("*** FAILED ***");
		$finish;
	end

	// receiver side: random stalls plus an optional long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_frame(frame_t'(s_axis_tdata));
			frames_accepted++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_reading(m_axis_tdata, m_axis_tuser[0]);
	end

	task automatic set_idle(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 84;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 84;
			end
			default: begin
				send_idle_pct = 20;
				recv_stall_pct = 20;
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_write(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input frame_t f);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// drop valid, let every reading come back, then let the pipeline settle
	task automatic wait_drained();
		stop_sending();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic frame_t good_frame(input logic [15:0] traw, input logic [15:0] hraw,
		input logic [7:0] tflip, input logic [7:0] hflip);
		frame_t f;
		f.temp_high = traw[15:8];
		f.temp_low = traw[7:0];
		f.temp_check = sb.crc_word(traw[15:8], traw[7:0]) ^ tflip;
		f.humid_high = hraw[15:8];
		f.humid_low = hraw[7:0];
		f.humid_check = sb.crc_word(hraw[15:8], hraw[7:0]) ^ hflip;
		return f;
	endfunction

	function automatic logic [15:0] random_raw();
		case ($urandom_range(19))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic frame_t random_frame();
		int roll;
		logic [7:0] tflip;
		logic [7:0] hflip;
		roll = $urandom_range(99);
		if (roll < 10)
			return frame_t'(IN_TDATA_W'({$urandom, $urandom}));
		tflip = 8'h00;
		hflip = 8'h00;
		if ((roll >= 80 && roll < 87) || roll >= 94)
			tflip = 8'($urandom_range(255, 1));
		if (roll >= 87)
			hflip = 8'($urandom_range(255, 1));
		return good_frame(random_raw(), random_raw(), tflip, hflip);
	endfunction

	initial begin
		frame_t f;
		sb = new();
		frames_accepted = 0;
		cfg_writes = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		set_idle(IDLE_NONE);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames at reset crc settings
		send_frame(good_frame(16'h0000, 16'h0000, 8'h00, 8'h00));
		send_frame(good_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00));
		send_frame(good_frame(16'hBEEF, 16'hBEEF, 8'h00, 8'h00));
		send_frame(good_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00));
		send_frame(good_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00));
		send_frame(good_frame(16'h8000, 16'h7FFF, 8'h00, 8'h00));
		send_frame(good_frame(16'h0001, 16'hFFFE, 8'h00, 8'h00));
		send_frame(good_frame(16'h6666, 16'h5555, 8'h01, 8'h00));
		send_frame(good_frame(16'h6666, 16'h5555, 8'h00, 8'h80));
		send_frame(good_frame(16'h6666, 16'h5555, 8'hFF, 8'hFF));
		send_frame(good_frame(16'h1234, 16'hABCD, 8'h00, 8'h00));
		f = frame_t'({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_frame(f);
		f = frame_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_frame(f);
		send_frame(good_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00));
		send_frame(good_frame(16'h0000, 16'h0000, 8'h00, 8'h00));
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_idle(IDLE_NONE);
				1: begin
					set_idle(IDLE_SEND);
					write_reg(REG_CRC_POLY, 8'h00);
					write_reg(REG_CRC_SEED, 8'h00);
				end
				2: begin
					set_idle(IDLE_RECV);
					write_reg(REG_CRC_POLY, 8'hFF);
					write_reg(REG_CRC_SEED, 8'hFF);
				end
				3: begin
					set_idle(IDLE_BOTH);
					write_reg(REG_CRC_POLY, 8'h07);
					write_reg(REG_CRC_SEED, 8'h00);
				end
				4: begin
					set_idle(IDLE_NONE);
					write_reg(REG_CRC_POLY, 8'($urandom_range(255)));
					write_reg(REG_CRC_SEED, 8'($urandom_range(255)));
					hold_cycles = 300;
				end
				5: begin
					set_idle(IDLE_SEND);
					write_reg(REG_CRC_SEED, 8'($urandom_range(255)));
					write_reg(8'($urandom_range(255, 2)), 8'($urandom_range(255)));
					write_reg(8'($urandom_range(255, 2)), 8'($urandom_range(255)));
				end
				6: begin
					set_idle(IDLE_RECV);
					write_reg(REG_CRC_POLY, POLY_RESET);
					write_reg(REG_CRC_SEED, SEED_RESET);
				end
				default: begin
					set_idle(IDLE_BOTH);
					write_reg(REG_CRC_POLY, 8'($urandom_range(255)));
					write_reg(REG_CRC_SEED, 8'($urandom_range(255)));
				end
			endcase
			for (int n = 0; n < 100; n++) begin
				if (ph == 6 && n == 50)
					wait_drained();
				send_frame(random_frame());
			end
			wait_drained();
		end

		$display("run covered %0d frames over 8 crc settings with %0d register writes",
			frames_accepted, cfg_writes);
		$display("%0d readings checked, %0d of them crc errors, %0d mismatches",
			sb.readings_checked, sb.crc_fail_readings, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
